>>> rtl/rfr_pkg.sv
// Shared types and constants of the response frame receiver.
// No dependencies; imported by the top level and its port checker.
package rfr_pkg;

  localparam logic [7:0]  SOF_BYTE     = 8'hBC;
  localparam logic [31:0] LEN_EXPECTED = 32'd8;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  // Input word kinds
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  // One result word
  typedef struct packed {
    status_t            status;
    logic signed [31:0] code;
  } result_t;

endpackage

>>> rtl/response_frame_receiver.sv
// Response frame receiver: frame hunt, length and checksum test, tick timeout.
// Depends on rfr_pkg.
//
// Usage:
//   s_* channel takes one word per accepted beat: s_tuser = 0 carries a received
//   byte in s_tdata, s_tuser = 1 is one time tick (s_tdata ignored).
//   While hunting, bytes are dropped until 0xBC opens a 16-byte frame.
//   The 16th byte yields one result; a tick beyond timeout_ticks yields a
//   timeout result. Other words yield nothing.
//   m_* channel carries results: m_tuser holds the status, m_tdata the
//   response code (frame word 2 on success, else zero).
//   cfg_* channel writes timeout_ticks (zero disables; always ready). The user
//   must write it only while the block is idle; the block does not enforce it.
// Timing:
//   One word per cycle while s_tready is high. A result goes into the result
//   register if that is empty or being taken, else into the skid entry. This
//   two-entry output buffer keeps s_tready high while one result waits;
//   s_tready drops only when both entries hold results the sink has not taken.
// Reset:
//   rst (synchronous, active high) returns to hunting, clears the tick count,
//   the timeout register and both output entries.
module response_frame_receiver
  import rfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] response_code (signed)
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  // Frame and timer state
  logic        in_frame, in_frame_next;
  logic [3:0]  byte_index, byte_index_next;
  logic [31:0] word_assembly, word_assembly_next;
  logic [31:0] running_sum, running_sum_next;
  logic        length_good, length_good_next;
  logic [31:0] code_word, code_word_next;
  logic [31:0] elapsed_ticks, elapsed_ticks_next;
  logic [31:0] timeout_ticks;

  // Output buffer
  logic    out_valid, skid_valid;
  result_t out_res, skid_res;

  logic    accept, pop, push;
  result_t new_res;
  logic [31:0] word_full;
  logic [1:0]  pos;
  logic [1:0]  widx;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign pop       = out_valid && m_tready;

  assign pos  = byte_index[1:0];
  assign widx = byte_index[3:2];

  // Insert the byte at its lane of the word being built
  always_comb begin
    word_full = word_assembly;
    word_full[{pos, 3'b000} +: 8] = s_tdata;
  end

  // Next state and result of one accepted word
  always_comb begin
    in_frame_next      = in_frame;
    byte_index_next    = byte_index;
    word_assembly_next = word_assembly;
    running_sum_next   = running_sum;
    length_good_next   = length_good;
    code_word_next     = code_word;
    elapsed_ticks_next = elapsed_ticks;
    push               = 1'b0;
    new_res.status     = ST_OK;
    new_res.code       = '0;

    if (opcode_t'(s_tuser[0]) == OP_TICK) begin
      if (timeout_ticks != '0 && elapsed_ticks >= timeout_ticks) begin
        // Time out: drop any partial frame and restart the wait
        push               = 1'b1;
        new_res.status     = ST_TIMEOUT;
        in_frame_next      = 1'b0;
        byte_index_next    = '0;
        word_assembly_next = '0;
        running_sum_next   = '0;
        length_good_next   = 1'b0;
        code_word_next     = '0;
        elapsed_ticks_next = '0;
      end else if (elapsed_ticks != '1) begin
        elapsed_ticks_next = elapsed_ticks + 32'd1;
      end
    end else if (!in_frame) begin
      // Hunt for the start byte
      if (s_tdata == SOF_BYTE) begin
        in_frame_next      = 1'b1;
        word_assembly_next = {24'd0, s_tdata};
        byte_index_next    = 4'd1;
        running_sum_next   = '0;
        length_good_next   = 1'b0;
        code_word_next     = '0;
      end
    end else begin
      word_assembly_next = word_full;
      byte_index_next    = byte_index + 4'd1;
      if (pos == 2'd3) begin
        if (widx != 2'd3) begin
          // Close a data word
          running_sum_next   = running_sum + word_full;
          word_assembly_next = '0;
          if (widx == 2'd1) begin
            length_good_next = (word_full == LEN_EXPECTED);
          end
          if (widx == 2'd2) begin
            code_word_next = word_full;
          end
        end else begin
          // Checksum word: judge the frame and go back to hunting
          push = 1'b1;
          priority if (!length_good) begin
            new_res.status = ST_BAD_LEN;
          end else if (word_full != running_sum) begin
            new_res.status = ST_BAD_SUM;
          end else begin
            new_res.status     = ST_OK;
            new_res.code       = code_word;
            elapsed_ticks_next = '0;
          end
          in_frame_next      = 1'b0;
          byte_index_next    = '0;
          word_assembly_next = '0;
          running_sum_next   = '0;
          length_good_next   = 1'b0;
          code_word_next     = '0;
        end
      end
    end
  end

  // Advance frame state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      byte_index    <= '0;
      word_assembly <= '0;
      running_sum   <= '0;
      length_good   <= 1'b0;
      code_word     <= '0;
      elapsed_ticks <= '0;
    end else if (accept) begin
      in_frame      <= in_frame_next;
      byte_index    <= byte_index_next;
      word_assembly <= word_assembly_next;
      running_sum   <= running_sum_next;
      length_good   <= length_good_next;
      code_word     <= code_word_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

  // Hold the timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= '0;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept && push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Result payloads
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (accept && push) begin
      if (!out_valid || pop) begin
        out_res <= new_res;
      end else begin
        skid_res <= new_res;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res.code;
  assign m_tuser  = out_res.status;

endmodule

>>> rtl/rfr_port_checker.sv
// Port-level checks for response_frame_receiver, bound to the top level.
// Depends on rfr_pkg.
module rfr_port_checker
  import rfr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown after reset");

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Only a good frame carries a response code
  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == 32'd0)
    else $error("nonzero code on a failed result");

  // Input stalls only while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no pending result");

  // A stalled sink with a full buffer keeps the input blocked
  a_stall_keep: assert property (@(posedge clk) disable iff (rst)
    !s_tready && !m_tready |=> !s_tready)
    else $error("input released while buffer still full");

endmodule

bind response_frame_receiver rfr_port_checker u_rfr_port_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
